// File: hw/rtl/ffra_pkg.sv
// Package: shared types and constants for the first-fit range allocator.
package ffra_pkg;

    localparam int FREE_ENTRIES = 16;
    localparam int OFFSET_BITS  = 32;
    localparam int IDX_BITS     = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CNT_BITS     = $clog2(FREE_ENTRIES + 1);
    localparam logic [31:0] REGION_RESET = 32'd65536;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] req_size;
        logic [31:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [31:0] alloc_offset;
        logic        alloc_failed;
        logic        table_overflow;
    } t_res;

    typedef enum logic [2:0] {
        TBL_NONE    = 3'd0,
        TBL_PUSH    = 3'd1,
        TBL_REPLACE = 3'd2,
        TBL_REMOVE  = 3'd3,
        TBL_WRITE   = 3'd4
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op                op;
        logic [IDX_BITS-1:0]    idx;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
    } t_tbl_cmd;

endpackage

// File: hw/rtl/ffra_table.sv
// Free range table: register array with push-front, replace, remove and write.
module ffra_table (
    input  logic                             i_clk,
    input  ffra_pkg::t_tbl_cmd               i_cmd,
    input  logic [ffra_pkg::IDX_BITS-1:0]    i_ridx,
    output logic [ffra_pkg::OFFSET_BITS-1:0] o_rd_start,
    output logic [ffra_pkg::OFFSET_BITS-1:0] o_rd_len
);

    logic [ffra_pkg::OFFSET_BITS-1:0] r_start [ffra_pkg::FREE_ENTRIES];
    logic [ffra_pkg::OFFSET_BITS-1:0] r_len   [ffra_pkg::FREE_ENTRIES];

    assign o_rd_start = r_start[i_ridx];
    assign o_rd_len   = r_len[i_ridx];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ffra_pkg::TBL_PUSH: begin
                for (int k = 1; k < ffra_pkg::FREE_ENTRIES; k++) begin
                    r_start[k] <= r_start[k-1];
                    r_len[k]   <= r_len[k-1];
                end
                r_start[0] <= i_cmd.start;
                r_len[0]   <= i_cmd.len;
            end
            ffra_pkg::TBL_REPLACE: begin
                // remove entry idx, leftover goes to the front
                for (int k = 1; k < ffra_pkg::FREE_ENTRIES; k++) begin
                    if (ffra_pkg::IDX_BITS'(k) <= i_cmd.idx) begin
                        r_start[k] <= r_start[k-1];
                        r_len[k]   <= r_len[k-1];
                    end
                end
                r_start[0] <= i_cmd.start;
                r_len[0]   <= i_cmd.len;
            end
            ffra_pkg::TBL_REMOVE: begin
                for (int k = 0; k < ffra_pkg::FREE_ENTRIES - 1; k++) begin
                    if (ffra_pkg::IDX_BITS'(k) >= i_cmd.idx) begin
                        r_start[k] <= r_start[k+1];
                        r_len[k]   <= r_len[k+1];
                    end
                end
            end
            ffra_pkg::TBL_WRITE: begin
                r_start[i_cmd.idx] <= i_cmd.start;
                r_len[i_cmd.idx]   <= i_cmd.len;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/first_fit_range_allocator_core.sv
// Top level: sequencer for the first-fit range allocator.
//
// Channel   Dir  Signals                 Handshake
// request   in   i_req (t_req)           accepted when start && !busy
// result    out  o_res (t_res)           o_valid high one cycle, no backpressure
// config    in   i_cfg_data (32 bits)    written when i_cfg_we
//
// Flow: allocate probes table entries one per cycle (none if the table is
//   empty), then falls back to the bump check; free either pulls the end
//   pointer down, flags overflow or pushes the range and, if the table held
//   entries, runs a merge pass, through a single read port and one compare/merge unit.
// Reset: end pointer and entry count clear, region size reloads 65536.
//   Table contents are not cleared; only entries below the count are read.
// Stalls: busy is high while a request is in flight; results cannot stall.
module first_fit_range_allocator_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  ffra_pkg::t_req i_req,
    output logic           o_valid,
    output ffra_pkg::t_res o_res,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data
);

    localparam int OB = ffra_pkg::OFFSET_BITS;
    localparam int IW = ffra_pkg::IDX_BITS;
    localparam int CW = ffra_pkg::CNT_BITS;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_BUMP   = 5'b00100,
        ST_MERGE  = 5'b01000,
        ST_MFIN   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    ffra_pkg::t_req       r_req, n_req;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]        r_i, n_i;
    logic [IW-1:0]        r_outn, n_outn;
    logic [OB-1:0]        r_cs, n_cs, r_cl, n_cl;
    logic [OB-1:0]        r_ep, n_ep;
    logic [31:0]          r_region, n_region;
    logic                 r_valid, n_valid;
    ffra_pkg::t_res       r_res, n_res;

    ffra_pkg::t_tbl_cmd   tbl_cmd;
    logic [OB-1:0]        rd_start, rd_len;

    ffra_table u_table (
        .i_clk      (i_clk),
        .i_cmd      (tbl_cmd),
        .i_ridx     (r_i),
        .o_rd_start (rd_start),
        .o_rd_len   (rd_len)
    );

    // request fields masked to the offset width
    logic [OB-1:0] in_size, in_offs, q_size;
    assign in_size = OB'(i_req.req_size);
    assign in_offs = OB'(i_req.free_offset);
    assign q_size  = OB'(r_req.req_size);

    // shared compare/merge unit, all sums at OB+1 bits
    logic [OB:0] c_end, b_end, m_end, m_lo, m_diff, bump_sum;
    logic        touch, last_i;
    logic [OB-1:0] m_len;
    assign c_end  = {1'b0, r_cs} + {1'b0, r_cl};
    assign b_end  = {1'b0, rd_start} + {1'b0, rd_len};
    assign touch  = (r_cs < rd_start) ? (c_end >= {1'b0, rd_start})
                                      : (b_end >= {1'b0, r_cs});
    assign m_end  = (b_end > c_end) ? b_end : c_end;
    assign m_lo   = (r_cs < rd_start) ? {1'b0, r_cs} : {1'b0, rd_start};
    assign m_diff = m_end - m_lo;
    assign m_len  = m_diff[OB] ? {OB{1'b1}} : m_diff[OB-1:0];
    assign bump_sum = {1'b0, r_ep} + {1'b0, q_size};
    assign last_i = (CW'(r_i) == r_cnt - CW'(1));

    always_comb begin
        logic [OB:0] fsum;
        n_state  = r_state;
        n_req    = r_req;
        n_cnt    = r_cnt;
        n_i      = r_i;
        n_outn   = r_outn;
        n_cs     = r_cs;
        n_cl     = r_cl;
        n_ep     = r_ep;
        n_region = i_cfg_we ? i_cfg_data : r_region;
        n_valid  = 1'b0;
        n_res    = '0;
        tbl_cmd  = '{op: ffra_pkg::TBL_NONE, idx: r_i, start: r_cs, len: r_cl};
        fsum     = {1'b0, in_offs} + {1'b0, in_size};

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    n_i   = '0;
                    if (i_req.op == ffra_pkg::OP_ALLOC) begin
                        n_state = (r_cnt == '0) ? ST_BUMP : ST_SEARCH;
                    end else if (fsum == {1'b0, r_ep}) begin
                        // freed range sits at the top: pull end pointer down
                        n_ep    = r_ep - in_size;
                        n_valid = 1'b1;
                    end else if (r_cnt == CW'(ffra_pkg::FREE_ENTRIES)) begin
                        n_res.table_overflow = 1'b1;
                        n_valid = 1'b1;
                    end else begin
                        tbl_cmd = '{op: ffra_pkg::TBL_PUSH, idx: '0,
                                    start: in_offs, len: in_size};
                        n_cnt   = r_cnt + CW'(1);
                        if (r_cnt != '0) begin
                            n_state = ST_MERGE;
                            n_i     = IW'(1);
                            n_outn  = '0;
                            n_cs    = in_offs;
                            n_cl    = in_size;
                        end else begin
                            n_valid = 1'b1;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (rd_len >= q_size) begin
                    if (rd_len != q_size) begin
                        tbl_cmd = '{op: ffra_pkg::TBL_REPLACE, idx: r_i,
                                    start: rd_start + q_size, len: rd_len - q_size};
                    end else begin
                        tbl_cmd = '{op: ffra_pkg::TBL_REMOVE, idx: r_i,
                                    start: rd_start, len: rd_len};
                        n_cnt   = r_cnt - CW'(1);
                    end
                    n_res.alloc_offset = 32'(rd_start);
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else if (last_i) begin
                    n_state = ST_BUMP;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            ST_BUMP: begin
                if (bump_sum >= (OB+1)'(r_region)) begin
                    n_res.alloc_failed = 1'b1;
                end else begin
                    n_res.alloc_offset = 32'(r_ep);
                    n_ep = bump_sum[OB-1:0];
                end
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_MERGE: begin
                if (touch) begin
                    n_cs = m_lo[OB-1:0];
                    n_cl = m_len;
                end else begin
                    tbl_cmd = '{op: ffra_pkg::TBL_WRITE, idx: r_outn,
                                start: r_cs, len: r_cl};
                    n_outn  = r_outn + IW'(1);
                    n_cs    = rd_start;
                    n_cl    = rd_len;
                end
                if (last_i) begin
                    n_state = ST_MFIN;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            ST_MFIN: begin
                tbl_cmd = '{op: ffra_pkg::TBL_WRITE, idx: r_outn,
                            start: r_cs, len: r_cl};
                n_cnt   = CW'(r_outn) + CW'(1);
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ep     <= '0;
            r_region <= ffra_pkg::REGION_RESET;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ep     <= n_ep;
            r_region <= n_region;
            r_valid  <= n_valid;
        end
        r_req  <= n_req;
        r_i    <= n_i;
        r_outn <= n_outn;
        r_cs   <= n_cs;
        r_cl   <= n_cl;
        r_res  <= n_res;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ffra_pkg::FREE_ENTRIES)) else $error("entry count overrun");
    a_merge_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE) |-> (r_outn < r_i)) else $error("merge write passed read");
    a_req_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid)) else $error("request dropped");

endmodule
